[hw/rtl/psi_pkg.sv]
// Shared types, register codes and reset values of the profile setpoint interpolator.
package psi_pkg;

    localparam int unsigned PROFILE_DEPTH_DEF = 256;
    localparam int unsigned CFG_IDX_W         = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VELOCITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME        = 2'd2;

    // Register reset values: scale 1.0, default 1.0, ramp 50 ms.
    localparam logic signed [31:0] SCALE_RESET   = 32'sd65536;
    localparam logic signed [31:0] DEFAULT_RESET = 32'sd65536;
    localparam logic [31:0]        RAMP_RESET    = 32'd50000;

    // Word kinds on the command channel.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [31:0]        sample_time;
        logic signed [31:0] point_velocity;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] target_velocity;
        logic               load_rejected;
    } res_word_t;

endpackage

[hw/rtl/psi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module psi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/profile_setpoint_interpolator.sv]
// Top level of the profile setpoint interpolator: breakpoint table, sequencer and shared datapath.
//
// The block keeps a table of up to PROFILE_DEPTH breakpoints (time in microseconds,
// velocity in Q16.16) and answers query words with a target velocity. A load word
// (kind 0) appends one breakpoint; when the table is full the breakpoint is dropped
// and the result word carries load_rejected set. Every command word produces exactly
// one result word; loads return a target of zero. A query (kind 1) clamps to the first
// or last breakpoint outside the table, otherwise finds the neighbours by a binary
// search and interpolates linearly between them; an empty table gives the default
// velocity. The value is then multiplied by velocity_scale (saturated to 32 bits) and,
// while the query time is below ramp_time, by time/ramp_time. Breakpoints should be
// loaded in rising time order; an unsorted table still gives a defined answer.
// The block handles one word at a time and stalls the command channel while busy.
// A query that clamps or meets an empty table skips the search and the interpolation
// multiply and division; a query at or past ramp_time, or with the ramp off, skips
// the ramp multiply and division. The time a query takes is set by the single
// 32x32 multiplier and the shared restoring divider, which retires one quotient bit
// per cycle and runs once for the interpolation and once for the ramp, and by the
// binary search, which spends a read state and a check state (S_SRCH_RD, S_SRCH_CHK)
// per probe on the registered table read port. A finished result sits in an output
// register, so a new command word is taken while the previous result still waits
// on a stalled result channel. Configuration writes are accepted in every cycle and
// must only be issued while the block is idle.
module profile_setpoint_interpolator #(
    parameter int unsigned PROFILE_DEPTH = psi_pkg::PROFILE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command channel.
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  psi_pkg::cmd_word_t                 cmd_word,
    // Result channel.
    output logic                               res_valid,
    input  logic                               res_stall,
    output psi_pkg::res_word_t                 res_word,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);

    import psi_pkg::*;

    localparam int unsigned AW = $clog2(PROFILE_DEPTH);
    localparam int unsigned CW = $clog2(PROFILE_DEPTH + 1);

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_RD_FIRST   = 20'h00002,
        S_CHK_FIRST  = 20'h00004,
        S_RD_LAST    = 20'h00008,
        S_CHK_LAST   = 20'h00010,
        S_SRCH_RD    = 20'h00020,
        S_SRCH_CHK   = 20'h00040,
        S_RD_END     = 20'h00080,
        S_TAKE_END   = 20'h00100,
        S_RD_LOW     = 20'h00200,
        S_RD_HIGH    = 20'h00400,
        S_CHK_PAIR   = 20'h00800,
        S_SCALE_PREP = 20'h01000,
        S_MUL        = 20'h02000,
        S_DIV        = 20'h04000,
        S_INTERP_ADD = 20'h08000,
        S_SCALE_SAT  = 20'h10000,
        S_RAMP_PREP  = 20'h20000,
        S_RAMP_DONE  = 20'h40000,
        S_FINISH     = 20'h80000
    } state_t;

    // Which step the shared multiplier and divider are serving.
    typedef enum logic [1:0] {
        PH_INTERP = 2'd0,
        PH_SCALE  = 2'd1,
        PH_RAMP   = 2'd2
    } phase_t;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        magnitude = v[31] ? (~v + 32'd1) : v;
    endfunction

    // Control state.
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               res_valid_reg, res_valid_next;

    // Configuration registers.
    logic signed [31:0] scale_reg;
    logic signed [31:0] dflt_reg;
    logic [31:0]        ramp_reg;

    // Datapath registers.
    logic [31:0]        t_reg, t_next;
    logic signed [31:0] x_reg, x_next;
    logic [31:0]        t1_reg, t1_next;
    logic [31:0]        v1_reg, v1_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [31:0]        op_a_reg, op_a_next;
    logic [31:0]        op_b_reg, op_b_next;
    logic [31:0]        div_reg, div_next;
    logic               neg_reg, neg_next;
    logic               rej_reg, rej_next;
    logic [63:0]        acc_reg, acc_next;
    logic [4:0]         step_reg, step_next;
    res_word_t          res_word_reg, res_word_next;

    // Table interface.
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_t;
    logic [31:0]        rd_v;

    // Combinational helpers.
    logic               cmd_accept;
    logic               table_full;
    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      lo_m1;
    logic [CW-1:0]      mid_calc;
    logic [32:0]        trial;
    logic [32:0]        trial_diff;
    logic               trial_ge;
    logic [32:0]        dv;
    logic [31:0]        dv_mag;
    logic [47:0]        scaled;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;

    assign table_full = (count_reg >= CW'(PROFILE_DEPTH));
    assign count_m1   = count_reg - CW'(1);
    assign lo_m1      = lo_reg - CW'(1);
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign wr_en = cmd_accept && (cmd_word.kind == KIND_LOAD) && !table_full;

    // One restoring division step: the remainder always stays below the divisor.
    assign trial      = {acc_reg[63:32], acc_reg[31]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});

    assign dv     = {rd_v[31], rd_v} - {v1_reg[31], v1_reg};
    assign dv_mag = dv[32] ? 32'(~dv + 33'd1) : dv[31:0];
    assign scaled = acc_reg[63:16];

    psi_ram #(
        .WIDTH (32),
        .DEPTH (PROFILE_DEPTH)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd_word.sample_time),
        .rd_addr (rd_addr),
        .rd_data (rd_t)
    );

    psi_ram #(
        .WIDTH (32),
        .DEPTH (PROFILE_DEPTH)
    ) u_vel_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd_word.point_velocity),
        .rd_addr (rd_addr),
        .rd_data (rd_v)
    );

    // Table read address for the states that issue a read.
    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            S_RD_LAST:  rd_addr = count_m1[AW-1:0];
            S_SRCH_RD:  rd_addr = mid_calc[AW-1:0];
            S_RD_END:   rd_addr = (lo_reg == '0) ? '0 : count_m1[AW-1:0];
            S_RD_LOW:   rd_addr = lo_m1[AW-1:0];
            S_RD_HIGH:  rd_addr = lo_reg[AW-1:0];
            default:    rd_addr = '0;
        endcase
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && res_stall;
        t_next         = t_reg;
        x_next         = x_reg;
        t1_next        = t1_reg;
        v1_next        = v1_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        rej_next       = rej_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        res_word_next  = res_word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    t_next   = cmd_word.sample_time;
                    rej_next = 1'b0;
                    if (cmd_word.kind == KIND_LOAD)
                    begin
                        x_next     = '0;
                        rej_next   = table_full;
                        state_next = S_FINISH;
                        if (!table_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        x_next     = dflt_reg;
                        state_next = S_SCALE_PREP;
                    end
                    else
                    begin
                        state_next = S_RD_FIRST;
                    end
                end
            end

            S_RD_FIRST:
            begin
                state_next = S_CHK_FIRST;
            end

            S_CHK_FIRST:
            begin
                if (t_reg <= rd_t)
                begin
                    x_next     = rd_v;
                    state_next = S_SCALE_PREP;
                end
                else
                begin
                    state_next = S_RD_LAST;
                end
            end

            S_RD_LAST:
            begin
                state_next = S_CHK_LAST;
            end

            S_CHK_LAST:
            begin
                if (t_reg >= rd_t)
                begin
                    x_next     = rd_v;
                    state_next = S_SCALE_PREP;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH_RD;
                end
            end

            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_SRCH_CHK;
                end
                else if ((lo_reg >= count_reg) || (lo_reg == '0))
                begin
                    state_next = S_RD_END;
                end
                else
                begin
                    state_next = S_RD_LOW;
                end
            end

            S_SRCH_CHK:
            begin
                if (rd_t < t_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_RD;
            end

            S_RD_END:
            begin
                state_next = S_TAKE_END;
            end

            S_TAKE_END:
            begin
                x_next     = rd_v;
                state_next = S_SCALE_PREP;
            end

            S_RD_LOW:
            begin
                state_next = S_RD_HIGH;
            end

            S_RD_HIGH:
            begin
                t1_next    = rd_t;
                v1_next    = rd_v;
                state_next = S_CHK_PAIR;
            end

            S_CHK_PAIR:
            begin
                if ((t1_reg < rd_t) && (t1_reg <= t_reg) && (t_reg <= rd_t))
                begin
                    op_a_next  = dv_mag;
                    op_b_next  = t_reg - t1_reg;
                    div_next   = rd_t - t1_reg;
                    neg_next   = dv[32];
                    x_next     = v1_reg;
                    phase_next = PH_INTERP;
                    state_next = S_MUL;
                end
                else
                begin
                    x_next     = rd_v;
                    state_next = S_SCALE_PREP;
                end
            end

            S_SCALE_PREP:
            begin
                op_a_next  = magnitude(x_reg);
                op_b_next  = magnitude(scale_reg);
                neg_next   = x_reg[31] ^ scale_reg[31];
                phase_next = PH_SCALE;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                acc_next  = 64'(op_a_reg) * 64'(op_b_reg);
                step_next = '0;
                case (phase_reg)
                    PH_SCALE: state_next = S_SCALE_SAT;
                    default:  state_next = S_DIV;
                endcase
            end

            S_DIV:
            begin
                acc_next  = {trial_ge ? trial_diff[31:0] : trial[31:0],
                             acc_reg[30:0], trial_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    case (phase_reg)
                        PH_INTERP: state_next = S_INTERP_ADD;
                        default:   state_next = S_RAMP_DONE;
                    endcase
                end
            end

            S_INTERP_ADD:
            begin
                // The quotient never exceeds the velocity step, so no overflow here.
                x_next     = neg_reg ? (x_reg - $signed(acc_reg[31:0]))
                                     : (x_reg + $signed(acc_reg[31:0]));
                state_next = S_SCALE_PREP;
            end

            S_SCALE_SAT:
            begin
                if (neg_reg)
                begin
                    x_next = (scaled[47:31] != '0) ? 32'sh8000_0000
                                                   : $signed(~scaled[31:0] + 32'd1);
                end
                else
                begin
                    x_next = (scaled[47:31] != '0) ? 32'sh7FFF_FFFF
                                                   : $signed(scaled[31:0]);
                end
                state_next = S_RAMP_PREP;
            end

            S_RAMP_PREP:
            begin
                if (t_reg < ramp_reg)
                begin
                    op_a_next  = magnitude(x_reg);
                    op_b_next  = t_reg;
                    div_next   = ramp_reg;
                    neg_next   = x_reg[31];
                    phase_next = PH_RAMP;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_RAMP_DONE:
            begin
                x_next     = neg_reg ? $signed(~acc_reg[31:0] + 32'd1)
                                     : $signed(acc_reg[31:0]);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_word_next.target_velocity = x_reg;
                    res_word_next.load_rejected   = rej_reg;
                    res_valid_next                = 1'b1;
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SCALE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RESET;
            dflt_reg      <= DEFAULT_RESET;
            ramp_reg      <= RAMP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_VELOCITY_SCALE:   scale_reg <= $signed(cfg_data);
                    CFG_DEFAULT_VELOCITY: dflt_reg  <= $signed(cfg_data);
                    CFG_RAMP_TIME:        ramp_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        x_reg        <= x_next;
        t1_reg       <= t1_next;
        v1_reg       <= v1_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        div_reg      <= div_next;
        neg_reg      <= neg_next;
        rej_reg      <= rej_next;
        acc_reg      <= acc_next;
        step_reg     <= step_next;
        res_word_reg <= res_word_next;
    end

endmodule

[hw/rtl/psi_checker.sv]
// Port-level assertions for the profile setpoint interpolator and their bind.
module psi_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  psi_pkg::cmd_word_t            cmd_word,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  psi_pkg::res_word_t            res_word
);

    // A stalled command word stays offered and unchanged.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
        else $error("command word dropped or changed while stalled");

    // A stalled result word stays offered and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word dropped or changed while stalled");

    // A rejected load never carries a target velocity.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.load_rejected |-> res_word.target_velocity == 32'sd0)
        else $error("rejected load returned a nonzero target");

    // The block works on one word at a time: it is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken again before the previous word finished");

    // A new result only appears at the end of a word's work, never while idle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result word appeared without a word in progress");

endmodule

bind profile_setpoint_interpolator psi_checker u_psi_checker (.*);

[tb/sv/tb_profile_setpoint_interpolator.sv]
// Self-checking testbench for the profile setpoint interpolator.
module tb_profile_setpoint_interpolator;
    import psi_pkg::*;

    localparam int unsigned DEPTH         = PROFILE_DEPTH_DEF;
    // Sorted breakpoints are appended until this many loads have been made.
    // Later loads carry arbitrary times, and the last ones overflow the table.
    localparam int unsigned SORTED_LOADS  = 216;
    localparam int          RANDOM_PHASES = 20;
    localparam int          PHASE_WORDS   = 96;
    // Allow many times the worst idle stretch: the long receiver hold-off plus
    // a query and a sender gap.
    localparam int          QUIET_LIMIT   = 20000;
    localparam int          REPORT_LIMIT  = 100;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          HOLD_AFTER    = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_word_t            cmd_word = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_word_t            res_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    profile_setpoint_interpolator #(.PROFILE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Command words waiting to be sent. The front word is the one on the bus;
    // it leaves the backlog only when the block accepts it, at which point its
    // expected result is appended to expected_targets in the same step.
    cmd_word_t cmd_backlog[$];
    res_word_t expected_targets[$];

    // Predictor copy of the breakpoint table and the registers.
    logic [31:0]        bp_time [DEPTH];
    logic signed [31:0] bp_vel  [DEPTH];
    int unsigned        bp_count = 0;
    logic signed [31:0] cur_scale   = SCALE_RESET;
    logic signed [31:0] cur_default = DEFAULT_RESET;
    logic [31:0]        cur_ramp    = RAMP_RESET;

    // Stimulus bookkeeping: loads made so far, the latest sorted time and every
    // loaded time, so that queries can land on and around real breakpoints.
    int unsigned gen_loads = 0;
    logic [31:0] gen_last_time = '0;
    logic [31:0] gen_times[$];

    int mismatches = 0;
    int delivered = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    function automatic logic [63:0] magnitude(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // Rebuild a signed value from a magnitude and a sign, clipping to 32 bits.
    function automatic logic signed [31:0] saturate_signed(input logic [63:0] m,
                                                         input logic neg);
        if (neg)
        begin
            if (m >= 64'h8000_0000)
            begin
                return 32'sh8000_0000;
            end
            return -$signed(m[31:0]);
        end
        if (m > 64'h7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    // Q16.16 product, magnitude truncated toward zero, then saturated.
    function automatic logic signed [31:0] q16_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return saturate_signed(magnitude(p) >> 16, p < 0);
    endfunction

    // Clamp at the ends, otherwise find the first breakpoint at or after t by
    // a lower-bound search and interpolate from its left neighbour. A pair that
    // does not bracket t (unsorted table or equal times) yields the right entry.
    function automatic logic signed [31:0] table_lookup(input logic [31:0] t);
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic [31:0]        t1;
        logic [31:0]        t2;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        longint             delta;
        logic [63:0]        step;
        longint             sum;
        if (t <= bp_time[0])
        begin
            return bp_vel[0];
        end
        if (t >= bp_time[bp_count - 1])
        begin
            return bp_vel[bp_count - 1];
        end
        lo = 0;
        hi = bp_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (bp_time[mid] < t)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid;
            end
        end
        if (lo >= bp_count)
        begin
            return bp_vel[bp_count - 1];
        end
        if (lo == 0)
        begin
            return bp_vel[0];
        end
        t1 = bp_time[lo - 1];
        t2 = bp_time[lo];
        v1 = bp_vel[lo - 1];
        v2 = bp_vel[lo];
        if (!(t1 < t2 && t1 <= t && t <= t2))
        begin
            return v2;
        end
        delta = longint'(v2) - longint'(v1);
        step = (magnitude(delta) * {32'd0, t - t1}) / {32'd0, t2 - t1};
        sum = longint'(v1) + ((delta < 0) ? -longint'(step) : longint'(step));
        return sum[31:0];
    endfunction

    // Expected result of one accepted word; loads update the table copy.
    function automatic res_word_t predict_setpoint(input cmd_word_t w);
        res_word_t          r;
        logic signed [31:0] x;
        logic [63:0]        m;
        r.target_velocity = '0;
        r.load_rejected   = 1'b0;
        if (w.kind == KIND_LOAD)
        begin
            if (bp_count >= DEPTH)
            begin
                r.load_rejected = 1'b1;
            end
            else
            begin
                bp_time[bp_count] = w.sample_time;
                bp_vel[bp_count]  = w.point_velocity;
                bp_count++;
            end
            return r;
        end
        x = (bp_count == 0) ? cur_default : table_lookup(w.sample_time);
        x = q16_product(x, cur_scale);
        // Startup ramp: scale by time / ramp_time while below the ramp length.
        if (cur_ramp != 0 && w.sample_time < cur_ramp)
        begin
            m = (magnitude(longint'(x)) * {32'd0, w.sample_time}) / {32'd0, cur_ramp};
            x = saturate_signed(m, x < 0);
        end
        r.target_velocity = x;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_query(input logic [31:0] t);
        cmd_word_t w;
        w.kind           = KIND_QUERY;
        w.sample_time    = t;
        w.point_velocity = $urandom;
        cmd_backlog = {cmd_backlog, w};
    endtask

    task automatic queue_load(input logic [31:0] t, input logic [31:0] v, input logic sorted);
        cmd_word_t w;
        w.kind           = KIND_LOAD;
        w.sample_time    = t;
        w.point_velocity = v;
        cmd_backlog = {cmd_backlog, w};
        gen_loads++;
        gen_times = {gen_times, t};
        if (sorted)
        begin
            gen_last_time = t;
        end
    endtask

    function automatic logic [31:0] small_signed();
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    // Q16.16 register value: the extremes, unity, minus one, zero, small values or anything.
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'h0001_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0000;
            4: return 32'hFFFF_0000;
            9: return $urandom;
            default: return small_signed();
        endcase
    endfunction

    function automatic logic [31:0] pick_ramp();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return RAMP_RESET;
            3: return 32'hFFFF_FFFF;
            4: return $urandom;
            default: return $urandom_range(1, 32'h0200_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return small_signed();
            default: return $urandom;
        endcase
    endfunction

    // One random word. While the table is being built the loads come in rising
    // time order (with some repeated times); later loads have arbitrary times
    // and finally run into the full table. Queries aim mostly inside the loaded
    // span and at or next to breakpoints, else below the ramp, at time extremes or anywhere.
    task automatic queue_random_word();
        logic [32:0] sum;
        logic [31:0] t;
        int unsigned load_pct;
        load_pct = (gen_loads < SORTED_LOADS) ? 22 : 12;
        if ($urandom_range(0, 99) < load_pct)
        begin
            if (gen_loads < SORTED_LOADS)
            begin
                case ($urandom_range(0, 9))
                    0: sum = {1'b0, gen_last_time};
                    1, 2, 3, 4: sum = {1'b0, gen_last_time} + 33'($urandom_range(1, 1000));
                    default: sum = {1'b0, gen_last_time}
                                   + 33'($urandom_range(1, 32'h00FF_FFFF));
                endcase
                t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                queue_load(t, pick_velocity(), 1'b1);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: t = $urandom;
                    1: t = 32'd0;
                    2: t = 32'hFFFF_FFFF;
                    default: t = $urandom_range(0, gen_last_time);
                endcase
                queue_load(t, pick_velocity(), 1'b0);
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: t = $urandom_range(0, gen_last_time);
                4, 5: t = gen_times[$urandom_range(0, gen_times.size() - 1)]
                          + 32'($urandom_range(0, 2)) - 32'd1;
                6: t = (cur_ramp == 0) ? $urandom : $urandom_range(0, cur_ramp);
                7: t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                default: t = $urandom;
            endcase
            queue_query(t);
        end
    endtask

    // Register write on the configuration channel; the predictor follows it
    // at the edge where the write takes effect.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_VELOCITY_SCALE:   cur_scale = data;
            CFG_DEFAULT_VELOCITY: cur_default = data;
            CFG_RAMP_TIME:        cur_ramp = data;
            default: ;
        endcase
    endtask

    // The sender pauses here until every queued word has been answered.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || expected_targets.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table with the reset settings: ramp factor zero at time zero,
        // half way up the ramp, exactly at its end and far beyond it.
        queue_query(32'd0);
        queue_query(32'd25000);
        queue_query(32'd50000);
        queue_query(32'hFFFF_FFFF);
        wait_drained();

        // Largest scale and default with the longest ramp.
        write_register(CFG_VELOCITY_SCALE, 32'h7FFF_FFFF);
        write_register(CFG_DEFAULT_VELOCITY, 32'h7FFF_FFFF);
        write_register(CFG_RAMP_TIME, 32'hFFFF_FFFF);
        queue_query(32'hFFFF_FFFE);
        queue_query(32'h8000_0000);
        wait_drained();

        // Most negative scale and default: the product overflows upward; with
        // the largest default it saturates downward. Ramp off.
        write_register(CFG_VELOCITY_SCALE, 32'h8000_0000);
        write_register(CFG_DEFAULT_VELOCITY, 32'h8000_0000);
        write_register(CFG_RAMP_TIME, 32'd0);
        queue_query(32'h1234_5678);
        wait_drained();
        write_register(CFG_DEFAULT_VELOCITY, 32'h7FFF_FFFF);
        queue_query(32'd0);
        wait_drained();

        // Unity scale, negative default, one-microsecond ramp.
        write_register(CFG_VELOCITY_SCALE, 32'h0001_0000);
        write_register(CFG_DEFAULT_VELOCITY, 32'hFFFF_0000);
        write_register(CFG_RAMP_TIME, 32'd1);
        queue_query(32'd0);
        queue_query(32'd1);

        // First breakpoints: velocity extremes, a repeated time, then queries
        // that clamp low, interpolate across the full velocity span, land on a
        // breakpoint, interpolate after the repeated time and clamp high.
        queue_load(32'd0, 32'h7FFF_FFFF, 1'b1);
        queue_load(32'd1000, 32'h8000_0000, 1'b1);
        queue_load(32'd1000, 32'd0, 1'b1);
        queue_load(32'd5000, 32'd12345, 1'b1);
        queue_query(32'd0);
        queue_query(32'd500);
        queue_query(32'd1000);
        queue_query(32'd3000);
        queue_query(32'd5000);
        queue_query(32'hFFFF_FFFF);

        // Random phases, each under settings of its own.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            write_register(CFG_VELOCITY_SCALE, pick_q16());
            write_register(CFG_DEFAULT_VELOCITY, pick_q16());
            write_register(CFG_RAMP_TIME, pick_ramp());
            repeat (PHASE_WORDS) queue_random_word();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Command driver: bursts of random length separated by random gaps. A
    // word stays on the bus unchanged until accepted; the next one is put on
    // the bus at the edge that accepts it unless a gap is due.
    // ------------------------------------------------------------------

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_targets = {expected_targets, predict_setpoint(cmd_backlog[0])};
                cmd_backlog.pop_front();
            end
            if (!(cmd_valid && cmd_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_word  <= cmd_backlog[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall pattern: modes that never stall, stall lightly, stall half
    // the time or stall heavily, each kept for a random stretch. Once, after
    // a few hundred results, the receiver holds off for a long stretch so the
    // block's output register fills and it stalls the command channel.
    // ------------------------------------------------------------------

    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end
            else if (!hold_done && delivered >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                res_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(20, 200);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 7) == 0);
                    2: res_stall <= ($urandom_range(0, 1) == 1);
                    default: res_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result word against the oldest expectation.
    // ------------------------------------------------------------------

    res_word_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            delivered <= delivered + 1;
            if (expected_targets.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing outstanding", res_word));
            end
            else
            begin
                oldest = expected_targets.pop_front();
                if (res_word.target_velocity !== oldest.target_velocity)
                begin
                    report_mismatch($sformatf("target_velocity %h, want %h",
                                              res_word.target_velocity,
                                              oldest.target_velocity));
                end
                if (res_word.load_rejected !== oldest.load_rejected)
                begin
                    report_mismatch($sformatf("load_rejected %b, want %b",
                                              res_word.load_rejected,
                                              oldest.load_rejected));
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any handshake ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
